[sv/rne_pkg.sv]
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Shared types, constants and the control store of the encoder sequencer.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned SymbolW = 7;
  localparam int unsigned UpcW    = 4;
  localparam int unsigned NumDenoms = 13;

  localparam logic [ValueW-1:0] MaxValue = 12'd3999;

  typedef logic [UpcW-1:0]    upc_t;
  typedef logic [ValueW-1:0]  value_t;
  typedef logic [SymbolW-1:0] symbol_t;

  // Control store addresses that are not denominations.
  localparam upc_t UpcErr = upc_t'(NumDenoms);

  localparam symbol_t SymI = 7'h49;
  localparam symbol_t SymV = 7'h56;
  localparam symbol_t SymX = 7'h58;
  localparam symbol_t SymL = 7'h4C;
  localparam symbol_t SymC = 7'h43;
  localparam symbol_t SymD = 7'h44;
  localparam symbol_t SymM = 7'h4D;
  localparam symbol_t SymNone = 7'h00;

  typedef struct packed {
    value_t  denom;
    symbol_t sym0;
    symbol_t sym1;
    logic    pair;
    logic    err;
  } ctrl_word_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic   load;
    logic   step;
    value_t denom;
  } dp_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    upc_t fit;
    logic zero;
    logic in_range;
  } dp_status_t;

  function automatic ctrl_word_t ctrl_rom(input upc_t upc);
    ctrl_word_t cw;
    cw = '{denom: '0, sym0: SymNone, sym1: SymNone, pair: 1'b0, err: 1'b1};
    case (upc)
      4'd0:  cw = '{denom: 12'd1000, sym0: SymM, sym1: SymNone, pair: 1'b0, err: 1'b0};
      4'd1:  cw = '{denom: 12'd900,  sym0: SymC, sym1: SymM,    pair: 1'b1, err: 1'b0};
      4'd2:  cw = '{denom: 12'd500,  sym0: SymD, sym1: SymNone, pair: 1'b0, err: 1'b0};
      4'd3:  cw = '{denom: 12'd400,  sym0: SymC, sym1: SymD,    pair: 1'b1, err: 1'b0};
      4'd4:  cw = '{denom: 12'd100,  sym0: SymC, sym1: SymNone, pair: 1'b0, err: 1'b0};
      4'd5:  cw = '{denom: 12'd90,   sym0: SymX, sym1: SymC,    pair: 1'b1, err: 1'b0};
      4'd6:  cw = '{denom: 12'd50,   sym0: SymL, sym1: SymNone, pair: 1'b0, err: 1'b0};
      4'd7:  cw = '{denom: 12'd40,   sym0: SymX, sym1: SymL,    pair: 1'b1, err: 1'b0};
      4'd8:  cw = '{denom: 12'd10,   sym0: SymX, sym1: SymNone, pair: 1'b0, err: 1'b0};
      4'd9:  cw = '{denom: 12'd9,    sym0: SymI, sym1: SymX,    pair: 1'b1, err: 1'b0};
      4'd10: cw = '{denom: 12'd5,    sym0: SymV, sym1: SymNone, pair: 1'b0, err: 1'b0};
      4'd11: cw = '{denom: 12'd4,    sym0: SymI, sym1: SymV,    pair: 1'b1, err: 1'b0};
      4'd12: cw = '{denom: 12'd1,    sym0: SymI, sym1: SymNone, pair: 1'b0, err: 1'b0};
      default: cw = '{denom: '0, sym0: SymNone, sym1: SymNone, pair: 1'b0, err: 1'b1};
    endcase
    return cw;
  endfunction

  // Address of the largest denomination that fits into v.
  function automatic upc_t first_fit(input value_t v);
    upc_t       res;
    ctrl_word_t cw;
    res = upc_t'(NumDenoms - 1);
    for (int i = NumDenoms - 1; i >= 0; i--) begin
      cw = ctrl_rom(upc_t'(i));
      if (v >= cw.denom) begin
        res = upc_t'(i);
      end
    end
    return res;
  endfunction

endpackage

[sv/rne_datapath.sv]
// ----------------------------------------------------------------------------
// Roman numeral encoder datapath
// Holds the remainder, subtracts the current denomination and finds the next
// denomination that fits.
// ----------------------------------------------------------------------------
module rne_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rne_pkg::value_t     value_i,
  input  rne_pkg::dp_ctrl_t   ctrl_i,
  output rne_pkg::dp_status_t status_o
);

  rne_pkg::value_t rest_q, rest_d;
  rne_pkg::value_t rest_sub;
  rne_pkg::value_t search;

  assign rest_sub = rest_q - ctrl_i.denom;
  assign search   = ctrl_i.load ? value_i : rest_sub;

  always_comb begin
    rest_d = rest_q;
    if (ctrl_i.load) begin
      rest_d = value_i;
    end else if (ctrl_i.step) begin
      rest_d = rest_sub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= '0;
    end else begin
      rest_q <= rest_d;
    end
  end

  assign status_o.fit      = rne_pkg::first_fit(search);
  assign status_o.zero     = (rest_sub == '0);
  assign status_o.in_range = (value_i != '0) && (value_i <= rne_pkg::MaxValue);

endmodule

[sv/rne_sequencer.sv]
// ----------------------------------------------------------------------------
// Roman numeral encoder sequencer
// Steps through the control store, one character per cycle, and jumps to the
// next fitting denomination after each one.
// ----------------------------------------------------------------------------
module rne_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rne_pkg::dp_status_t status_i,
  output rne_pkg::dp_ctrl_t   ctrl_o,
  output logic                valid_o,
  output rne_pkg::symbol_t    symbol_o,
  output logic                last_o,
  output logic                error_o
);

  logic               busy_q, busy_d;
  logic               half_q, half_d;
  rne_pkg::upc_t      upc_q, upc_d;
  rne_pkg::ctrl_word_t cw;
  logic               load;
  logic               second;

  assign cw     = rne_pkg::ctrl_rom(upc_q);
  assign load   = start && !busy_q;
  assign second = cw.pair && !half_q;

  always_comb begin
    busy_d       = busy_q;
    half_d       = half_q;
    upc_d        = upc_q;
    ctrl_o.load  = load;
    ctrl_o.step  = 1'b0;
    ctrl_o.denom = cw.denom;
    symbol_o     = rne_pkg::SymNone;
    last_o       = 1'b0;
    error_o      = 1'b0;
    if (load) begin
      busy_d = 1'b1;
      half_d = 1'b0;
      upc_d  = status_i.in_range ? status_i.fit : rne_pkg::UpcErr;
    end else if (busy_q) begin
      if (cw.err) begin
        last_o  = 1'b1;
        error_o = 1'b1;
        busy_d  = 1'b0;
      end else if (second) begin
        symbol_o = cw.sym0;
        half_d   = 1'b1;
      end else begin
        symbol_o    = cw.pair ? cw.sym1 : cw.sym0;
        ctrl_o.step = 1'b1;
        last_o      = status_i.zero;
        half_d      = 1'b0;
        upc_d       = status_i.fit;
        busy_d      = !status_i.zero;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      half_q <= 1'b0;
      upc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      half_q <= half_d;
      upc_q  <= upc_d;
    end
  end

  assign busy    = busy_q;
  assign valid_o = busy_q;

endmodule

[sv/roman_numeral_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Roman numeral encoder
// Converts a 12-bit integer into its Roman numeral, one ASCII letter a cycle.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. From the next cycle the
// letters follow, most significant first, one per cycle with valid_o high, and
// last_o marks the final one; the receiver cannot stall, so every letter must
// be taken in the cycle it is shown. The block stays busy while the letters of
// a numeral are shown, so a new value is taken only after its last letter; the
// longest numeral is that of 3888. A value of 0 or above 3999 gives a single
// result with error_o and last_o set and symbol 0.
module roman_numeral_encoder_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [11:0]            value_i,
  output logic                   valid_o,
  output logic [6:0]             symbol_o,
  output logic                   last_o,
  output logic                   error_o
);

  rne_pkg::dp_ctrl_t   dp_ctrl;
  rne_pkg::dp_status_t dp_status;

  rne_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .ctrl_o   (dp_ctrl),
    .valid_o  (valid_o),
    .symbol_o (symbol_o),
    .last_o   (last_o),
    .error_o  (error_o)
  );

  rne_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (value_i),
    .ctrl_i   (dp_ctrl),
    .status_o (dp_status)
  );

endmodule
